// File: rtl/rf3_pkg.sv
package rf3_pkg;

    localparam int WIN_SIZE        = 9;
    localparam int WIN_CENTER      = 4;
    localparam int RANK_BITS       = 4;
    localparam int MIN_DIM         = 3;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 13;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;

    localparam int WIDTH_RESET     = 1024;
    localparam int HEIGHT_RESET    = 1024;

    localparam logic [RANK_BITS-1:0] RANK_MAX   = 4'd8;
    localparam logic [RANK_BITS-1:0] RANK_RESET = 4'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_RANK_SELECT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } beat_ctrl_t;

endpackage

// File: rtl/rf3_rank.sv
module rf3_rank
    import rf3_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] window,
    input  logic [RANK_BITS-1:0]                rank,
    output logic [PIXEL_BITS-1:0]               value
);

    logic [WIN_SIZE-1:0][RANK_BITS-1:0] place;

    // place of each element in sorted order, ties broken by position
    always_comb
    begin
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            place[i] = '0;
            for (int j = 0; j < WIN_SIZE; j++)
            begin
                if (j != i)
                begin
                    if ((window[j] < window[i]) || ((j < i) && (window[j] == window[i])))
                    begin
                        place[i] = place[i] + RANK_BITS'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        value = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (place[i] == rank)
            begin
                value = window[i];
            end
        end
    end

endmodule

// File: rtl/rank_filter_3x3_stream.sv
// Streaming 3x3 rank filter for a raster-order frame of PIXEL_BITS-bit pixels, one pixel per
// beat with s_tuser = 0. Each interior pixel becomes the value at sorted position rank_select
// of its 3x3 neighborhood (0 minimum, 4 median, 8 maximum, larger values act as 8); pixels on
// the first and last line and column pass through unchanged. The result for pixel q leaves
// with the beat that carries pixel q + image_width + 1, so after the last pixel send
// image_width + 1 drain beats (s_tuser = 1); m_tlast marks the last pixel of the frame. Drain
// beats during a frame and pixels while drain is pending are taken and dropped. Throughput is
// one beat per clock while m_tready keeps the output moving; after its beat is taken, a result
// passes the line-store read at the accepting edge, then the window shift, then the nine-input
// rank network into the output register. Two
// MAX_WIDTH-deep line stores with one read and one write port each hold the previous lines;
// they need no clearing pass, as entries not yet written never reach the output. Write
// image_width and image_height (clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT) only while idle;
// such a write restarts the frame.
module rank_filter_3x3_stream
    import rf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 8,
    localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [DATA_BITS-1:0]      s_tdata,   // pixel_in
    input  logic [0:0]                s_tuser,   // kind

    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_BITS-1:0]      m_tdata,   // pixel_out
    output logic                      m_tlast,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RB = $clog2(MAX_HEIGHT + 2);
    localparam int OB = $clog2(MAX_HEIGHT);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RESET = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WB-1:0]        eff_w_reg;
    logic [HB-1:0]        eff_h_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic [WB-1:0]        eff_w_next;
    logic [HB-1:0]        eff_h_next;
    logic [RANK_BITS-1:0] rank_next;

    logic [CB-1:0] in_col_reg;
    logic [RB-1:0] in_row_reg;
    logic [CB-1:0] out_col_reg;
    logic [OB-1:0] out_row_reg;
    logic [CB-1:0] in_col_next;
    logic [RB-1:0] in_row_next;
    logic [CB-1:0] out_col_next;
    logic [OB-1:0] out_row_next;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CB-1:0]         s1_col_reg;
    beat_ctrl_t            s1_ctrl_reg;
    beat_ctrl_t            s1_ctrl_next;

    logic                  s2_valid_reg;
    logic                  s2_interior_reg;
    logic                  s2_last_reg;

    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] out_pix_reg;
    logic                  out_last_reg;

    logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] win_reg;
    logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] win_next;

    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] up_rd_reg;
    logic [PIXEL_BITS-1:0] lo_rd_reg;

    logic                  accept;
    logic                  drain;
    logic                  drop;
    logic                  load;
    logic                  s1_adv;
    logic                  s2_adv;
    logic                  cfg_wr;
    logic                  geo_wr;
    logic [PIXEL_BITS-1:0] pix_in;
    logic [PIXEL_BITS-1:0] ranked;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geo_wr    = cfg_wr && ((cfg_index_t'(cfg_addr) == CFG_IMAGE_WIDTH)
                                  || (cfg_index_t'(cfg_addr) == CFG_IMAGE_HEIGHT));

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign drain  = s_tuser[0];
    assign drop   = drain ? (32'(in_row_reg) < 32'(eff_h_reg))
                          : (32'(in_row_reg) >= 32'(eff_h_reg));
    assign load   = accept && !drop;
    assign pix_in = drain ? '0 : s_tdata[PIXEL_BITS-1:0];

    // clamp geometry, saturate rank
    always_comb
    begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        rank_next  = rank_reg;
        case (cfg_index_t'(cfg_addr))
            CFG_IMAGE_WIDTH:
            begin
                if (32'(cfg_data[WIDTH_REG_BITS-1:0]) < MIN_DIM)
                    eff_w_next = WB'(MIN_DIM);
                else if (32'(cfg_data[WIDTH_REG_BITS-1:0]) > MAX_WIDTH)
                    eff_w_next = WB'(MAX_WIDTH);
                else
                    eff_w_next = WB'(cfg_data[WIDTH_REG_BITS-1:0]);
            end
            CFG_IMAGE_HEIGHT:
            begin
                if (32'(cfg_data[HEIGHT_REG_BITS-1:0]) < MIN_DIM)
                    eff_h_next = HB'(MIN_DIM);
                else if (32'(cfg_data[HEIGHT_REG_BITS-1:0]) > MAX_HEIGHT)
                    eff_h_next = HB'(MAX_HEIGHT);
                else
                    eff_h_next = HB'(cfg_data[HEIGHT_REG_BITS-1:0]);
            end
            CFG_RANK_SELECT:
            begin
                if (cfg_data[RANK_BITS-1:0] > RANK_MAX)
                    rank_next = RANK_MAX;
                else
                    rank_next = cfg_data[RANK_BITS-1:0];
            end
            default:
            begin
                rank_next = rank_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg <= WB'(W_RESET);
            eff_h_reg <= HB'(H_RESET);
            rank_reg  <= RANK_RESET;
        end
        else if (cfg_wr)
        begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
            rank_reg  <= rank_next;
        end
    end

    // frame position bookkeeping at the input
    always_comb
    begin
        s1_ctrl_next.emit = drain || (32'(in_row_reg) >= 2)
                            || ((32'(in_row_reg) == 1) && (32'(in_col_reg) >= 1));
        s1_ctrl_next.interior = (32'(out_row_reg) >= 1)
                                && (32'(out_row_reg) + 2 <= 32'(eff_h_reg))
                                && (32'(out_col_reg) >= 1)
                                && (32'(out_col_reg) + 2 <= 32'(eff_w_reg));
        s1_ctrl_next.last = s1_ctrl_next.emit
                            && (32'(out_row_reg) + 1 == 32'(eff_h_reg))
                            && (32'(out_col_reg) + 1 == 32'(eff_w_reg));

        in_col_next = CB'(32'(in_col_reg) + 1);
        in_row_next = in_row_reg;
        if (32'(in_col_reg) + 1 >= 32'(eff_w_reg))
        begin
            in_col_next = '0;
            in_row_next = RB'(32'(in_row_reg) + 1);
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s1_ctrl_next.emit)
        begin
            out_col_next = CB'(32'(out_col_reg) + 1);
            if (32'(out_col_reg) + 1 >= 32'(eff_w_reg))
            begin
                out_col_next = '0;
                out_row_next = OB'(32'(out_row_reg) + 1);
            end
        end

        if (s1_ctrl_next.last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (geo_wr)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (load)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            up_rd_reg <= upper_mem[in_col_reg];
            lo_rd_reg <= lower_mem[in_col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            upper_mem[s1_col_reg] <= lo_rd_reg;
            lower_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_pix_reg  <= pix_in;
            s1_col_reg  <= in_col_reg;
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    // shift window one column
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_rd_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = lo_rd_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_ctrl_reg.emit;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_interior_reg <= s1_ctrl_reg.interior;
            s2_last_reg     <= s1_ctrl_reg.last;
        end
    end

    rf3_rank #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_rank (
        .window (win_reg),
        .rank   (rank_reg),
        .value  (ranked)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_pix_reg  <= s2_interior_reg ? ranked : win_reg[WIN_CENTER];
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_BITS'(out_pix_reg);
    assign m_tlast  = out_last_reg;

    a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> $stable(win_reg))
        else $error("window moved under a pending result");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && s1_ctrl_next.last && !geo_wr)
        |=> (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0)
            && (out_row_reg == '0))
        else $error("counters not cleared after end of frame");

    a_in_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_row_reg) <= 32'(eff_h_reg) + 1)
        else $error("input row beyond drain range");

    a_out_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(out_row_reg) < 32'(eff_h_reg))
        else $error("output row beyond frame");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s2_adv)
        else $error("pending result overwritten");

endmodule

// File: test/rank_filter_3x3_stream_checker.sv
`timescale 1ns / 1ps

module rank_filter_3x3_stream_checker
    import rf3_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,   // pixel_in
    input  logic [0:0]                s_tuser,   // kind

    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [7:0]                m_tdata,   // pixel_out
    input  logic                      m_tlast,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    output int                        mismatches,
    output int                        outstanding
);

    localparam int LINE_DEPTH   = 1024;
    localparam int MAX_LINES    = 4096;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_end;
    } filtered_pixel_t;

    filtered_pixel_t            predicted_pixels[$];
    logic [7:0]                 upper_line [LINE_DEPTH];
    logic [7:0]                 lower_line [LINE_DEPTH];
    logic [7:0]                 window [WIN_SIZE];
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;
    logic [RANK_BITS-1:0]       rank_reg;
    int                         in_col;
    int                         in_row;
    int                         out_col;
    int                         out_row;
    int                         fault_count;
    int                         results_seen;

    function automatic int clamp_dim(int value, int limit);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [7:0] ranked_pixel();
        logic [7:0]           sorted [WIN_SIZE];
        logic [7:0]           swap;
        logic [RANK_BITS-1:0] pick;
        sorted = window;
        for (int i = 0; i < WIN_SIZE - 1; i++)
        begin
            for (int j = 0; j < WIN_SIZE - 1 - i; j++)
            begin
                if (sorted[j] > sorted[j+1])
                begin
                    swap        = sorted[j];
                    sorted[j]   = sorted[j+1];
                    sorted[j+1] = swap;
                end
            end
        end
        pick = (rank_reg > RANK_MAX) ? RANK_MAX : rank_reg;
        return sorted[pick];
    endfunction

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic shift_column(logic [7:0] pix, int w);
        logic [7:0] up;
        logic [7:0] lo;
        up = upper_line[in_col];
        lo = lower_line[in_col];
        upper_line[in_col] = lo;
        lower_line[in_col] = pix;
        for (int r = 0; r < 3; r++)
        begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = up;
        window[5] = lo;
        window[8] = pix;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] value);
        case (index)
            CFG_IMAGE_WIDTH:
            begin
                width_reg = value[WIDTH_REG_BITS-1:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT:
            begin
                height_reg = value[HEIGHT_REG_BITS-1:0];
                restart_frame();
            end
            CFG_RANK_SELECT:
                rank_reg = value[RANK_BITS-1:0];
            default:
                ;
        endcase
    endtask

    task automatic filter_beat(logic drain, logic [7:0] pix);
        int              w;
        int              h;
        logic            emit;
        logic            interior;
        filtered_pixel_t item;
        w = clamp_dim(int'(width_reg), LINE_DEPTH);
        h = clamp_dim(int'(height_reg), MAX_LINES);
        if (drain)
        begin
            if (in_row < h)
                return;
            emit = 1'b1;
            shift_column(8'd0, w);
        end
        else
        begin
            if (in_row >= h)
                return;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            shift_column(pix, w);
        end
        if (!emit)
            return;
        interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
        item.pixel     = interior ? ranked_pixel() : window[WIN_CENTER];
        item.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
        predicted_pixels.push_back(item);
        if (item.frame_end)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic check_beat(logic [7:0] pixel, logic frame_end);
        filtered_pixel_t want;
        results_seen++;
        if (predicted_pixels.size() == 0)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("output %0d: unexpected beat, pixel %0d last %0b",
                         results_seen, pixel, frame_end);
            return;
        end
        want = predicted_pixels.pop_front();
        if (want.pixel !== pixel || want.frame_end !== frame_end)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("output %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                         results_seen, want.pixel, want.frame_end, pixel, frame_end);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            width_reg  = WIDTH_REG_BITS'(WIDTH_RESET);
            height_reg = HEIGHT_REG_BITS'(HEIGHT_RESET);
            rank_reg   = RANK_RESET;
            restart_frame();
            predicted_pixels.delete();
            fault_count  = 0;
            results_seen = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_addr, cfg_data);
            if (s_tvalid && s_tready)
                filter_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast);
            mismatches  <= fault_count;
            outstanding <= predicted_pixels.size();
        end
    end

endmodule

// File: test/rank_filter_3x3_stream_test.sv
`timescale 1ns / 1ps

module rank_filter_3x3_stream_test;
    import rf3_pkg::*;

    localparam logic [0:0]                KIND_PIXEL    = 1'b0;
    localparam logic [0:0]                KIND_DRAIN    = 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE     = 2'd3;
    localparam int                        MAX_GAP       = 14;
    localparam int                        SETTLE_CYCLES = 8;
    localparam int                        RANDOM_ITEMS  = 1300;
    localparam int                        MAX_COLS      = 1024;
    localparam int                        MAX_ROWS      = 4096;
    localparam int                        WIDE_TAIL     = 8;
    localparam int                        TALL_ROWS     = 10;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;
    logic [0:0]                s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [7:0]                m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    int width_val      = WIDTH_RESET;
    int height_val     = HEIGHT_RESET;
    int counted        = 0;

    always #4 clk = ~clk;

    rank_filter_3x3_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    rank_filter_3x3_stream_checker filter_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int clamp_dim(int value, int limit);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic logic [7:0] next_pixel(int style);
        case (style)
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2:       return 8'd100 + 8'($urandom_range(0, 3));
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return 8'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_beat(logic [0:0] kind, logic [7:0] pixel);
        int gap;
        gap = draw_gap(sender_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pixel;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index,
                             logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == CFG_IMAGE_WIDTH)
            width_val = int'(value[WIDTH_REG_BITS-1:0]);
        else if (index == CFG_IMAGE_HEIGHT)
            height_val = int'(value[HEIGHT_REG_BITS-1:0]);
    endtask

    // hold off until every predicted beat has left the block
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(int w, int h, int cut, int style);
        int total;
        total = w * h + w + 1;
        for (int b = 0; b < total; b++)
        begin
            if (b == cut)
                return;
            if (b < w * h)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_beat(KIND_DRAIN, 8'($urandom));
                send_beat(KIND_PIXEL, next_pixel(style));
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(KIND_PIXEL, 8'($urandom));
                send_beat(KIND_DRAIN, 8'($urandom));
            end
            counted++;
        end
    endtask

    initial
    begin
        int gap;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_quiet = !receiver_quiet;
            gap = draw_gap(receiver_quiet);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        int phase;
        int w;
        int h;
        int frames;
        int cut;
        bit need_restart;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame with clamped geometry and saturated rank
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        write_reg(CFG_RANK_SELECT, 13'd15);
        write_reg(CFG_SPARE, 13'h1FFF);
        for (int i = 0; i < 9; i++)
        begin
            send_beat(KIND_PIXEL, (i == 4) ? 8'h5A : ((i % 2 == 0) ? 8'hFF : 8'h00));
            if (i == 4)
                send_beat(KIND_DRAIN, 8'hFF);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_beat(KIND_DRAIN, 8'h00);
            if (i == 1)
                send_beat(KIND_PIXEL, 8'hA5);
        end
        settle();

        counted      = 0;
        phase        = 0;
        need_restart = 1'b0;
        while (counted < RANDOM_ITEMS || phase < 8)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                write_reg(CFG_IMAGE_WIDTH, 13'd2047);
                write_reg(CFG_IMAGE_HEIGHT, 13'd1);
            end
            else if (phase == 6)
            begin
                write_reg(CFG_IMAGE_WIDTH, 13'd0);
                write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
            end
            else
            begin
                if (need_restart || $urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(0, 2)));
                        1:       write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(13, 40)));
                        default: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(3, 12)));
                    endcase
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(0, 2)));
                        1:       write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(8, 16)));
                        default: write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(3, 6)));
                    endcase
                end
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_RANK_SELECT, 13'($urandom_range(0, 15)));

            w            = clamp_dim(width_val, MAX_COLS);
            h            = clamp_dim(height_val, MAX_ROWS);
            frames       = (phase == 3 || phase == 6) ? 1 : $urandom_range(1, 3);
            need_restart = 1'b0;
            for (int f = 0; f < frames; f++)
            begin
                cut = -1;
                // clamped geometry: stop a few rows in
                if (phase == 3 || phase == 6)
                begin
                    cut          = (phase == 3) ? w + WIDE_TAIL : TALL_ROWS * w;
                    need_restart = 1'b1;
                end
                else if (f == frames - 1 && $urandom_range(0, 5) == 0)
                begin
                    cut          = $urandom_range(0, w * h + w);
                    need_restart = 1'b1;
                end
                send_frame(w, h, cut, $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2));
            end
            settle();
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("rank_filter_3x3_stream: match");
        else
            $display("rank_filter_3x3_stream: mismatch");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("rank_filter_3x3_stream: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/rf3_pkg.sv
rtl/rf3_rank.sv
rtl/rank_filter_3x3_stream.sv
test/rank_filter_3x3_stream_checker.sv
test/rank_filter_3x3_stream_test.sv
